[rtl/gcr62_pkg.sv]
`default_nettype none
package gcr62_pkg;

   localparam int unsigned AUX_LEN   = 86;
   localparam int unsigned AUX_AW    = $clog2(AUX_LEN);
   localparam int unsigned POS_W     = 9;
   localparam int unsigned GRP_W     = 2;
   localparam int unsigned GRP_LAST  = 2;

   localparam logic [POS_W-1:0] POS_PRO_LAST   = 9'd2;
   localparam logic [POS_W-1:0] POS_CODED      = 9'd3;
   localparam logic [POS_W-1:0] POS_DATA       = 9'd89;
   localparam logic [POS_W-1:0] POS_CHECKSUM   = 9'd345;
   localparam logic [POS_W-1:0] POS_EPI        = 9'd346;
   localparam logic [POS_W-1:0] POS_LAST       = 9'd348;
   localparam logic [POS_W-1:0] CODED_CHAINED  = 9'h156;

   localparam logic [7:0] PRO_MARK0 = 8'hd5;
   localparam logic [7:0] PRO_MARK1 = 8'haa;
   localparam logic [7:0] PRO_MARK2 = 8'had;
   localparam logic [7:0] EPI_MARK0 = 8'hde;
   localparam logic [7:0] EPI_MARK1 = 8'haa;
   localparam logic [7:0] EPI_MARK2 = 8'heb;

   localparam logic KIND_DATA    = 1'b0;
   localparam logic KIND_VERDICT = 1'b1;

   localparam logic [1:0] STATUS_GOOD    = 2'd0;
   localparam logic [1:0] STATUS_BAD_PRO = 2'd1;
   localparam logic [1:0] STATUS_BAD_EPI = 2'd2;

   localparam logic [7:0] GCR_MAP [128] = '{
      8'hff,8'hff,8'hff,8'hff,8'hff,8'hff,8'hff,8'hff,
      8'hff,8'hff,8'hff,8'hff,8'hff,8'hff,8'hff,8'hff,
      8'hff,8'hff,8'hff,8'hff,8'hff,8'hff,8'h00,8'h04,
      8'hff,8'hff,8'h08,8'h0c,8'hff,8'h10,8'h14,8'h18,
      8'hff,8'hff,8'hff,8'hff,8'hff,8'hff,8'h1c,8'h20,
      8'hff,8'hff,8'hff,8'h24,8'h28,8'h2c,8'h30,8'h34,
      8'hff,8'hff,8'h38,8'h3c,8'h40,8'h44,8'h48,8'h4c,
      8'hff,8'h50,8'h54,8'h58,8'h5c,8'h60,8'h64,8'h68,
      8'hff,8'hff,8'hff,8'hff,8'hff,8'hff,8'hff,8'hff,
      8'hff,8'hff,8'hff,8'h6c,8'hff,8'h70,8'h74,8'h78,
      8'hff,8'hff,8'hff,8'h7c,8'hff,8'hff,8'h80,8'h84,
      8'hff,8'h88,8'h8c,8'h90,8'h94,8'h98,8'h9c,8'ha0,
      8'hff,8'hff,8'hff,8'hff,8'hff,8'ha4,8'ha8,8'hac,
      8'hff,8'hb0,8'hb4,8'hb8,8'hbc,8'hc0,8'hc4,8'hc8,
      8'hff,8'hff,8'hcc,8'hd0,8'hd4,8'hd8,8'hdc,8'he0,
      8'hff,8'he4,8'he8,8'hec,8'hf0,8'hf4,8'hf8,8'hfc
   };

   typedef struct packed {
      logic       valid;
      logic       item_kind;
      logic [7:0] data_byte;
      logic [7:0] byte_index;
      logic [1:0] frame_status;
      logic       last;
   } res_type;

endpackage
`default_nettype wire

[rtl/gcr62_ifs.sv]
`default_nettype none
interface gcr62_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] disk_byte;
   logic       sector_start;

   modport source (output valid, output disk_byte, output sector_start, input ready);
   modport sink   (input valid, input disk_byte, input sector_start, output ready);
endinterface

interface gcr62_rsp_if;
   logic       valid;
   logic       ready;
   logic       item_kind;
   logic [7:0] data_byte;
   logic [7:0] byte_index;
   logic [1:0] frame_status;
   logic       last;

   modport source (output valid, output item_kind, output data_byte, output byte_index,
                   output frame_status, output last, input ready);
   modport sink   (input valid, input item_kind, input data_byte, input byte_index,
                   input frame_status, input last, output ready);
endinterface
`default_nettype wire

[rtl/gcr62_core.sv]
`default_nettype none
module gcr62_core import gcr62_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic [7:0] disk_byte,
   input  logic       sector_start,
   output res_type    res
);

   logic [5:0]        aux_mem [AUX_LEN];
   logic [5:0]        aux_rd_ff;

   logic              active_ff, active_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [7:0]        xor_ff, xor_in;
   logic              ok_ff, ok_in;
   logic [AUX_AW-1:0] k_ff, k_in;
   logic [GRP_W-1:0]  grp_ff, grp_in;

   logic              act_eff, ok_eff;
   logic [POS_W-1:0]  pos_eff, coded_idx, data_idx;
   logic [7:0]        xor_eff, chain_val;
   logic [AUX_AW-1:0] k_eff;
   logic [GRP_W-1:0]  grp_eff;
   logic              pro_match, epi_match;
   logic [1:0]        epi_sel;
   logic [1:0]        low_bits;
   logic              wr_en;

   assign act_eff   = sector_start | active_ff;
   assign ok_eff    = sector_start | ok_ff;
   assign pos_eff   = sector_start ? '0 : pos_ff;
   assign xor_eff   = sector_start ? '0 : xor_ff;
   assign k_eff     = sector_start ? '0 : k_ff;
   assign grp_eff   = sector_start ? '0 : grp_ff;
   assign chain_val = GCR_MAP[disk_byte[6:0]] ^ xor_eff;
   assign coded_idx = pos_eff - POS_CODED;
   assign data_idx  = pos_eff - POS_DATA;
   assign epi_sel   = 2'(pos_eff - POS_EPI);

   always_comb begin
      case (pos_eff[1:0])
         2'd0:    pro_match = (disk_byte == PRO_MARK0);
         2'd1:    pro_match = (disk_byte == PRO_MARK1);
         2'd2:    pro_match = (disk_byte == PRO_MARK2);
         default: pro_match = 1'b0;
      endcase
      case (epi_sel)
         2'd0:    epi_match = (disk_byte == EPI_MARK0);
         2'd1:    epi_match = (disk_byte == EPI_MARK1);
         2'd2:    epi_match = (disk_byte == EPI_MARK2);
         default: epi_match = 1'b0;
      endcase
      case (grp_eff)
         2'd0:    low_bits = {aux_rd_ff[0], aux_rd_ff[1]};
         2'd1:    low_bits = {aux_rd_ff[2], aux_rd_ff[3]};
         2'd2:    low_bits = {aux_rd_ff[4], aux_rd_ff[5]};
         default: low_bits = 2'b00;
      endcase
   end

   always_comb begin
      active_in = active_ff;
      pos_in    = pos_ff;
      xor_in    = xor_ff;
      ok_in     = ok_ff;
      k_in      = k_ff;
      grp_in    = grp_ff;
      wr_en     = 1'b0;
      res       = '0;
      if (accept) begin
         active_in = act_eff;
         pos_in    = pos_eff;
         xor_in    = xor_eff;
         ok_in     = ok_eff;
         k_in      = k_eff;
         grp_in    = grp_eff;
         if (act_eff) begin
            if (pos_eff < POS_CODED) begin
               ok_in  = ok_eff & pro_match;
               pos_in = pos_eff + 1'b1;
               if (pos_eff == POS_PRO_LAST && !(ok_eff & pro_match)) begin
                  active_in        = 1'b0;
                  res.valid        = 1'b1;
                  res.item_kind    = KIND_VERDICT;
                  res.frame_status = STATUS_BAD_PRO;
                  res.last         = 1'b1;
               end
            end else if (pos_eff < POS_EPI) begin
               pos_in = pos_eff + 1'b1;
               if (coded_idx < CODED_CHAINED) begin
                  xor_in = chain_val;
                  if (pos_eff < POS_DATA) begin
                     wr_en = 1'b1;
                  end else begin
                     res.valid      = 1'b1;
                     res.item_kind  = KIND_DATA;
                     res.data_byte  = {chain_val[7:2], low_bits};
                     res.byte_index = data_idx[7:0];
                     if (k_eff == AUX_AW'(AUX_LEN - 1)) begin
                        k_in   = '0;
                        grp_in = grp_eff + 1'b1;
                     end else begin
                        k_in = k_eff + 1'b1;
                     end
                  end
               end
            end else if (pos_eff <= POS_LAST) begin
               ok_in  = ok_eff & epi_match;
               pos_in = pos_eff + 1'b1;
               if (pos_eff == POS_LAST) begin
                  active_in        = 1'b0;
                  res.valid        = 1'b1;
                  res.item_kind    = KIND_VERDICT;
                  res.frame_status = (ok_eff & epi_match) ? STATUS_GOOD : STATUS_BAD_EPI;
                  res.last         = 1'b1;
               end
            end else begin
               active_in = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         pos_ff    <= '0;
         xor_ff    <= '0;
         ok_ff     <= 1'b0;
         k_ff      <= '0;
         grp_ff    <= '0;
      end else begin
         active_ff <= active_in;
         pos_ff    <= pos_in;
         xor_ff    <= xor_in;
         ok_ff     <= ok_in;
         k_ff      <= k_in;
         grp_ff    <= grp_in;
      end
   end

   // prefetch the aux entry the next data word needs
   always_ff @(posedge clock) begin
      if (wr_en) begin
         aux_mem[coded_idx[AUX_AW-1:0]] <= chain_val[7:2];
      end
      aux_rd_ff <= aux_mem[k_in];
   end

   a_data_pos: assert property (@(posedge clock) disable iff (reset)
      (accept && res.valid && res.item_kind == KIND_DATA)
         |-> (pos_eff >= POS_DATA && pos_eff < POS_CHECKSUM))
      else $error("data word outside the six-bit span");

   a_data_index: assert property (@(posedge clock) disable iff (reset)
      (accept && res.valid && res.item_kind == KIND_DATA)
         |-> (res.byte_index == 8'(grp_eff * AUX_LEN + k_eff)))
      else $error("aux pointer out of step with byte index");

   a_k_range: assert property (@(posedge clock) disable iff (reset)
      k_ff < AUX_AW'(AUX_LEN))
      else $error("aux pointer past end");

   a_grp_range: assert property (@(posedge clock) disable iff (reset)
      grp_ff <= GRP_W'(GRP_LAST))
      else $error("aux group past end");

   a_verdict_ends: assert property (@(posedge clock) disable iff (reset)
      (accept && res.valid && res.item_kind == KIND_VERDICT) |=> !active_ff)
      else $error("frame still active after verdict");

endmodule
`default_nettype wire

[rtl/gcr62_out_stage.sv]
`default_nettype none
module gcr62_out_stage import gcr62_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    accept,
   input  res_type res,
   input  logic    out_ready,
   output logic    in_ready,
   output res_type out
);

   logic    valid_ff, valid_in;
   res_type word_ff;

   assign in_ready  = !valid_ff || out_ready;
   assign valid_in  = in_ready ? (accept && res.valid) : valid_ff;
   assign out       = '{valid:        valid_ff,
                        item_kind:    word_ff.item_kind,
                        data_byte:    word_ff.data_byte,
                        byte_index:   word_ff.byte_index,
                        frame_status: word_ff.frame_status,
                        last:         word_ff.last};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // hold the word while the sink stalls
   always_ff @(posedge clock) begin
      if (in_ready && accept && res.valid) begin
         word_ff <= res;
      end
   end

endmodule
`default_nettype wire

[rtl/gcr_six_and_two_sector_decoder.sv]
// Channel   Dir  Payload                                               Accept
// req_ch    in   disk_byte[7:0], sector_start                          valid && ready
// rsp_ch    out  item_kind, data_byte[7:0], byte_index[7:0],          valid && ready
//                frame_status[1:0], last
//
// One disk byte per cycle while the output is not stalled; a result appears in the cycle after its byte is taken.
// The aux table is read ahead of use from a registered read port.
// Reset clears frame state and the output valid; aux table contents stay undefined.
// A stalled output holds its word; input ready drops only while a word waits.
`default_nettype none
module gcr_six_and_two_sector_decoder import gcr62_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   gcr62_req_if.sink     req_ch,
   gcr62_rsp_if.source   rsp_ch
);

   logic    in_ready;
   logic    accept;
   res_type res;
   res_type out;

   assign accept       = req_ch.valid && in_ready;
   assign req_ch.ready = in_ready;

   gcr62_core u_core (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .disk_byte    (req_ch.disk_byte),
      .sector_start (req_ch.sector_start),
      .res          (res)
   );

   gcr62_out_stage u_out (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .res       (res),
      .out_ready (rsp_ch.ready),
      .in_ready  (in_ready),
      .out       (out)
   );

   assign rsp_ch.valid        = out.valid;
   assign rsp_ch.item_kind    = out.item_kind;
   assign rsp_ch.data_byte    = out.data_byte;
   assign rsp_ch.byte_index   = out.byte_index;
   assign rsp_ch.frame_status = out.frame_status;
   assign rsp_ch.last         = out.last;

endmodule
`default_nettype wire

[verif/tb.sv]
`timescale 1ns / 1ps
module tb;
   import gcr62_pkg::*;

   localparam int unsigned FRAME_BYTES = 349;
   localparam int unsigned EPI_POS     = 346;
   localparam int unsigned CHAINED     = 342;
   localparam int unsigned AUX_BYTES   = 86;
   localparam int unsigned ITEM_TARGET = 750;
   localparam int unsigned STALL_LIMIT = 3000;
   localparam int unsigned LONG_HOLD   = 400;
   localparam int unsigned N_DIRECTED  = 24;

   localparam logic [7:0] PROLOGUE [3] = '{8'hd5, 8'haa, 8'had};
   localparam logic [7:0] EPILOGUE [3] = '{8'hde, 8'haa, 8'heb};

   localparam logic [7:0] DECODE_TABLE [128] = '{
      8'hff,8'hff,8'hff,8'hff,8'hff,8'hff,8'hff,8'hff,
      8'hff,8'hff,8'hff,8'hff,8'hff,8'hff,8'hff,8'hff,
      8'hff,8'hff,8'hff,8'hff,8'hff,8'hff,8'h00,8'h04,
      8'hff,8'hff,8'h08,8'h0c,8'hff,8'h10,8'h14,8'h18,
      8'hff,8'hff,8'hff,8'hff,8'hff,8'hff,8'h1c,8'h20,
      8'hff,8'hff,8'hff,8'h24,8'h28,8'h2c,8'h30,8'h34,
      8'hff,8'hff,8'h38,8'h3c,8'h40,8'h44,8'h48,8'h4c,
      8'hff,8'h50,8'h54,8'h58,8'h5c,8'h60,8'h64,8'h68,
      8'hff,8'hff,8'hff,8'hff,8'hff,8'hff,8'hff,8'hff,
      8'hff,8'hff,8'hff,8'h6c,8'hff,8'h70,8'h74,8'h78,
      8'hff,8'hff,8'hff,8'h7c,8'hff,8'hff,8'h80,8'h84,
      8'hff,8'h88,8'h8c,8'h90,8'h94,8'h98,8'h9c,8'ha0,
      8'hff,8'hff,8'hff,8'hff,8'hff,8'ha4,8'ha8,8'hac,
      8'hff,8'hb0,8'hb4,8'hb8,8'hbc,8'hc0,8'hc4,8'hc8,
      8'hff,8'hff,8'hcc,8'hd0,8'hd4,8'hd8,8'hdc,8'he0,
      8'hff,8'he4,8'he8,8'hec,8'hf0,8'hf4,8'hf8,8'hfc
   };

   typedef struct packed {
      logic       item_kind;
      logic [7:0] data_byte;
      logic [7:0] byte_index;
      logic [1:0] frame_status;
      logic       last;
   } gcr_word_type;

   typedef enum logic [1:0] {CHK_MODEL, CHK_NOTHING, CHK_BAD_PROLOGUE} row_check_type;
   typedef enum logic [1:0] {FAULT_NONE, FAULT_PROLOGUE, FAULT_EPILOGUE} frame_fault_type;

   typedef struct packed {
      logic [7:0]    disk_byte;
      logic          sector_start;
      row_check_type chk;
   } dir_row_type;

   localparam gcr_word_type BAD_PRO_WORD = '{KIND_VERDICT, 8'h00, 8'h00, STATUS_BAD_PRO, 1'b1};

   localparam dir_row_type DIRECTED_ROWS [N_DIRECTED] = '{
      '{8'h00, 1'b0, CHK_NOTHING},
      '{8'hff, 1'b0, CHK_NOTHING},
      '{8'hd4, 1'b1, CHK_NOTHING},
      '{8'haa, 1'b0, CHK_NOTHING},
      '{8'had, 1'b0, CHK_BAD_PROLOGUE},
      '{8'hde, 1'b0, CHK_NOTHING},
      '{8'hd5, 1'b1, CHK_NOTHING},
      '{8'hab, 1'b0, CHK_NOTHING},
      '{8'had, 1'b0, CHK_BAD_PROLOGUE},
      '{8'hd5, 1'b1, CHK_NOTHING},
      '{8'haa, 1'b0, CHK_NOTHING},
      '{8'hac, 1'b0, CHK_BAD_PROLOGUE},
      '{8'hff, 1'b1, CHK_NOTHING},
      '{8'hff, 1'b0, CHK_NOTHING},
      '{8'hff, 1'b0, CHK_BAD_PROLOGUE},
      '{8'hd5, 1'b1, CHK_NOTHING},
      '{8'haa, 1'b0, CHK_NOTHING},
      '{8'hd5, 1'b1, CHK_NOTHING},
      '{8'haa, 1'b0, CHK_NOTHING},
      '{8'had, 1'b0, CHK_NOTHING},
      '{8'h96, 1'b0, CHK_MODEL},
      '{8'h00, 1'b1, CHK_NOTHING},
      '{8'h00, 1'b0, CHK_NOTHING},
      '{8'h00, 1'b0, CHK_BAD_PROLOGUE}
   };

   logic clock;
   logic reset;

   gcr62_req_if req_ch ();
   gcr62_rsp_if rsp_ch ();

   gcr_six_and_two_sector_decoder dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // predictor state
   int unsigned sec_pos;
   logic [7:0]  chain_val;
   logic [5:0]  aux_bits [AUX_BYTES];
   bit          marks_match;
   bit          sec_open;

   gcr_word_type decoded_q [$];
   int unsigned  valid_codes [$];
   int unsigned  mismatches;
   int unsigned  sent_bytes;
   int unsigned  idle_cycles;
   bit           steady_flow;
   bit           long_hold_req;

   initial clock = 1'b0;
   always #5 clock = ~clock;

   task automatic decode_disk_byte(input logic [7:0] b, input logic s,
                                   output bit has_word, output gcr_word_type w);
      int unsigned c;
      int unsigned d;
      int unsigned sh;
      logic [7:0]  v;
      logic [5:0]  a;
      has_word = 1'b0;
      w = '0;
      if (s) begin
         sec_open = 1'b1;
         sec_pos = 0;
         chain_val = 8'h00;
         marks_match = 1'b1;
      end
      if (!sec_open) return;
      if (sec_pos < 3) begin
         if (b != PROLOGUE[sec_pos]) marks_match = 1'b0;
         sec_pos++;
         if (sec_pos == 3 && !marks_match) begin
            sec_open = 1'b0;
            has_word = 1'b1;
            w = BAD_PRO_WORD;
         end
      end else if (sec_pos < EPI_POS) begin
         c = sec_pos - 3;
         sec_pos++;
         if (c < CHAINED) begin
            v = DECODE_TABLE[b[6:0]] ^ chain_val;
            chain_val = v;
            if (c < AUX_BYTES) begin
               aux_bits[c] = v[7:2];
            end else begin
               d = c - AUX_BYTES;
               sh = 2 * (d / AUX_BYTES);
               a = aux_bits[d % AUX_BYTES];
               has_word = 1'b1;
               w.item_kind = KIND_DATA;
               w.data_byte = {v[7:2], a[sh], a[sh+1]};
               w.byte_index = d[7:0];
               w.frame_status = STATUS_GOOD;
               w.last = 1'b0;
            end
         end
      end else if (sec_pos < FRAME_BYTES) begin
         if (b != EPILOGUE[sec_pos - EPI_POS]) marks_match = 1'b0;
         sec_pos++;
         if (sec_pos == FRAME_BYTES) begin
            sec_open = 1'b0;
            has_word = 1'b1;
            w.item_kind = KIND_VERDICT;
            w.frame_status = marks_match ? STATUS_GOOD : STATUS_BAD_EPI;
            w.last = 1'b1;
         end
      end else begin
         sec_open = 1'b0;
      end
   endtask

   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (steady_flow || r < 65) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [7:0] rand_code();
      logic [6:0] idx;
      if ($urandom_range(0, 9) == 0) return 8'($urandom_range(0, 255));
      idx = 7'(valid_codes[$urandom_range(0, valid_codes.size() - 1)]);
      return {($urandom_range(0, 7) != 0), idx};
   endfunction

   task automatic send_byte(input logic [7:0] b, input logic s, input row_check_type chk);
      int unsigned  gap;
      bit           got;
      gcr_word_type w;
      gap = pick_gap();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.disk_byte <= b;
      req_ch.sector_start <= s;
      do @(posedge clock); while (!req_ch.ready);
      sent_bytes++;
      decode_disk_byte(b, s, got, w);
      case (chk)
         CHK_MODEL: if (got) decoded_q.push_back(w);
         CHK_BAD_PROLOGUE: decoded_q.push_back(BAD_PRO_WORD);
         default: ;
      endcase
   endtask

   task automatic send_frame(input frame_fault_type fault, input int unsigned keep);
      int unsigned bad_at;
      logic [7:0]  b;
      bad_at = (fault == FAULT_PROLOGUE) ? $urandom_range(0, 2)
                                         : EPI_POS + $urandom_range(0, 2);
      for (int unsigned i = 0; i < keep && sent_bytes < ITEM_TARGET; i++) begin
         if (i < 3) b = PROLOGUE[i];
         else if (i < EPI_POS) b = rand_code();
         else b = EPILOGUE[i - EPI_POS];
         if (fault != FAULT_NONE && i == bad_at) b = b ^ 8'($urandom_range(1, 255));
         send_byte(b, i == 0, CHK_MODEL);
      end
   endtask

   task automatic wait_results_out();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (decoded_q.size() != 0);
   endtask

   initial begin
      reset <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.disk_byte <= 8'h00;
      req_ch.sector_start <= 1'b0;
      sec_pos = 0;
      chain_val = 8'h00;
      marks_match = 1'b0;
      sec_open = 1'b0;
      mismatches = 0;
      sent_bytes = 0;
      steady_flow = 1'b0;
      long_hold_req = 1'b0;
      for (int i = 0; i < 128; i++) begin
         if (DECODE_TABLE[i] != 8'hff) valid_codes.push_back(i);
      end
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < N_DIRECTED; i++) begin
         send_byte(DIRECTED_ROWS[i].disk_byte, DIRECTED_ROWS[i].sector_start,
                   DIRECTED_ROWS[i].chk);
      end

      // full-rate good frame, then a bad epilogue under a long output stall
      steady_flow = 1'b1;
      send_frame(FAULT_NONE, FRAME_BYTES);
      steady_flow = 1'b0;
      long_hold_req = 1'b1;
      send_frame(FAULT_EPILOGUE, FRAME_BYTES);
      wait_results_out();

      while (sent_bytes < ITEM_TARGET) begin
         case ($urandom_range(0, 9))
            0, 1: repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)), 1'b0,
                                                          CHK_MODEL);
            2, 3: send_frame(FAULT_PROLOGUE, $urandom_range(3, 8));
            4, 5, 6: send_frame(FAULT_NONE, $urandom_range(3, 120));
            7: send_frame(FAULT_EPILOGUE, FRAME_BYTES);
            default: send_frame(FAULT_NONE, FRAME_BYTES);
         endcase
         if ($urandom_range(0, 19) == 0) wait_results_out();
      end

      wait_results_out();
      repeat (20) @(posedge clock);
      if (mismatches == 0 && decoded_q.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   initial begin
      int unsigned r;
      rsp_ch.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         r = $urandom_range(0, 99);
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            rsp_ch.ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end else if (steady_flow || r < 60) begin
            rsp_ch.ready <= 1'b1;
            repeat (steady_flow ? 1 : $urandom_range(1, 20)) @(posedge clock);
         end else begin
            rsp_ch.ready <= 1'b0;
            repeat (r < 92 ? $urandom_range(1, 3) : $urandom_range(20, 60)) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      gcr_word_type act;
      gcr_word_type exp_w;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         act = '{rsp_ch.item_kind, rsp_ch.data_byte, rsp_ch.byte_index,
                 rsp_ch.frame_status, rsp_ch.last};
         if (decoded_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected word: kind %0d data %02h idx %0d status %0d last %0d",
                        act.item_kind, act.data_byte, act.byte_index,
                        act.frame_status, act.last);
         end else begin
            exp_w = decoded_q.pop_front();
            if (act.item_kind !== exp_w.item_kind || act.data_byte !== exp_w.data_byte ||
                act.byte_index !== exp_w.byte_index ||
                act.frame_status !== exp_w.frame_status || act.last !== exp_w.last) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp kind %0d data %02h idx %0d status %0d last %0d, %s",
                           exp_w.item_kind, exp_w.data_byte, exp_w.byte_index,
                           exp_w.frame_status, exp_w.last,
                           $sformatf("got kind %0d data %02h idx %0d status %0d last %0d",
                                     act.item_kind, act.data_byte, act.byte_index,
                                     act.frame_status, act.last));
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles == STALL_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

endmodule

[filelist.f]
rtl/gcr62_pkg.sv
rtl/gcr62_ifs.sv
rtl/gcr62_core.sv
rtl/gcr62_out_stage.sv
rtl/gcr_six_and_two_sector_decoder.sv
verif/tb.sv
